### design/bmss_pkg.sv
// Shared types and constants for the brush motor soft start block.
`default_nettype none

package bmss_pkg;

   // Command codes carried by each tick
   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_STOP  = 2'd2;

   // Register indexes (byte address 4*index)
   localparam logic [2:0] REG_COMP_OFFSET   = 3'd0;
   localparam logic [2:0] REG_COMP_SLOPE    = 3'd1;
   localparam logic [2:0] REG_DUTY_FLOOR    = 3'd2;
   localparam logic [2:0] REG_STEP_INTERVAL = 3'd3;
   localparam logic [2:0] REG_RAMP_TIME     = 3'd4;

   // Register reset values
   localparam logic [11:0] COMP_OFFSET_RST   = 12'd1657;
   localparam logic [9:0]  COMP_SLOPE_RST    = 10'd393;
   localparam logic [11:0] DUTY_FLOOR_RST    = 12'd500;
   localparam logic [7:0]  STEP_INTERVAL_RST = 8'd10;
   localparam logic [15:0] RAMP_TIME_RST     = 16'd1000;

   localparam logic [11:0] KICK_DUTY       = 12'd1000;
   localparam logic [11:0] RAMP_START_DUTY = 12'd100;
   localparam logic [11:0] DUTY_MAX        = 12'd4095;

   // x/1000 for x < 2^22: (x * ceil(2^32/1000)) >> 32
   localparam logic [22:0] RECIP_1000       = 23'd4294968;
   localparam int          RECIP_1000_SHIFT = 32;
   // x/100 for x < 2^12: (x * ceil(2^19/100)) >> 19
   localparam logic [12:0] RECIP_100        = 13'd5243;
   localparam int          RECIP_100_SHIFT  = 19;

   typedef struct packed {
      logic [11:0] comp_offset;
      logic [9:0]  comp_slope;
      logic [11:0] duty_floor;
   } comp_cfg_type;

   // Item leaving the compensation pipeline
   typedef struct packed {
      logic        valid;
      logic [1:0]  run_cmd;
      logic [11:0] comp_duty;
      logic [5:0]  ramp_step;
   } comp_item_type;

endpackage

`default_nettype wire

### design/bmss_comp.sv
// Battery compensation pipeline: duty target and its ramp increment per tick.
`default_nettype none

module bmss_comp (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         advance,
   input  wire                         in_valid,
   input  wire  [1:0]                  in_run_cmd,
   input  wire  [11:0]                 in_battery,
   input  bmss_pkg::comp_cfg_type      cfg,
   output bmss_pkg::comp_item_type     out_item
);

   localparam int RecipWidth = 45;
   localparam int DivWidth   = 25;

   logic        s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic [1:0]  s1_cmd_ff, s2_cmd_ff, s3_cmd_ff, s4_cmd_ff;
   logic [21:0] s1_prod_ff;
   logic [12:0] s2_quo_ff;
   logic [11:0] s3_comp_ff, s4_comp_ff;
   logic [5:0]  s4_step_ff;

   logic [21:0]           prod_in;
   logic [RecipWidth-1:0] recip_prod;
   logic [12:0]           quo_in;
   logic [13:0]           low_limit;
   logic [12:0]           diff;
   logic [11:0]           comp_in;
   logic [DivWidth-1:0]   div_prod;
   logic [5:0]            step_in;

   assign prod_in = 22'(cfg.comp_slope) * 22'(in_battery);

   assign recip_prod = RecipWidth'(s1_prod_ff) * RecipWidth'(bmss_pkg::RECIP_1000);
   assign quo_in     = recip_prod[bmss_pkg::RECIP_1000_SHIFT +: 13];

   // Clamp at the floor; offset - quotient below the floor covers the negative case too
   assign low_limit = 14'(s2_quo_ff) + 14'(cfg.duty_floor);
   assign diff      = {1'b0, cfg.comp_offset} - s2_quo_ff;
   assign comp_in   = (14'(cfg.comp_offset) < low_limit) ? cfg.duty_floor : diff[11:0];

   assign div_prod = DivWidth'(s3_comp_ff) * DivWidth'(bmss_pkg::RECIP_100);
   assign step_in  = div_prod[bmss_pkg::RECIP_100_SHIFT +: 6];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cmd_ff  <= in_run_cmd;
         s1_prod_ff <= prod_in;
         s2_cmd_ff  <= s1_cmd_ff;
         s2_quo_ff  <= quo_in;
         s3_cmd_ff  <= s2_cmd_ff;
         s3_comp_ff <= comp_in;
         s4_cmd_ff  <= s3_cmd_ff;
         s4_comp_ff <= s3_comp_ff;
         s4_step_ff <= step_in;
      end
   end

   assign out_item.valid     = s4_valid_ff;
   assign out_item.run_cmd   = s4_cmd_ff;
   assign out_item.comp_duty = s4_comp_ff;
   assign out_item.ramp_step = s4_step_ff;

endmodule

`default_nettype wire

### design/brush_motor_soft_start.sv
// Top level: brush motor soft start with kick, ramp and battery-compensated hold.
//
//   channel  | handshake         | payload
//   ---------+-------------------+-----------------------------------
//   req      | req_valid/ready   | req_run_cmd, req_battery_sample
//   rsp      | rsp_valid/ready   | rsp_brush_duty, rsp_ramp_phase
//   csr      | psel/penable/...  | paddr[4:0], pwdata, prdata
//
// One tick per cycle while no result waits on rsp_ready; a result passes through four
// compensation stages, the last feeding the state update into the result register.
// The whole pipeline holds while a result waits on rsp_ready.
// Synchronous reset clears the phase, duty, counters and all valid bits.
// pready is tied high; registers take writes at the access cycle.
`default_nettype none

module brush_motor_soft_start (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [1:0]  req_run_cmd,
   input  wire  [11:0] req_battery_sample,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [11:0] rsp_brush_duty,
   output logic [1:0]  rsp_ramp_phase,
   input  wire         psel,
   input  wire         penable,
   input  wire         pwrite,
   input  wire  [4:0]  paddr,
   input  wire  [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   typedef enum logic [1:0] {
      PH_STOP = 2'd0,
      PH_KICK = 2'd1,
      PH_RAMP = 2'd2
   } phase_type;

   logic [11:0] comp_offset_ff;
   logic [9:0]  comp_slope_ff;
   logic [11:0] duty_floor_ff;
   logic [7:0]  step_interval_ff;
   logic [15:0] ramp_time_ff;

   bmss_pkg::comp_cfg_type  comp_cfg;
   bmss_pkg::comp_item_type item;

   logic advance;
   logic csr_write;

   phase_type   phase_ff, phase_in, phase_cmd;
   logic [11:0] duty_ff, duty_in;
   logic [11:0] target_ff, target_in;
   logic [5:0]  inc_ff, inc_in;
   logic [15:0] start_ticks_ff, start_ticks_in, start_base;
   logic [7:0]  step_ticks_ff, step_ticks_in, step_base;
   logic [12:0] duty_sum;
   logic        rsp_valid_ff;
   logic [11:0] rsp_duty_ff;
   logic [1:0]  rsp_phase_ff;

   // Configuration registers
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         comp_offset_ff   <= bmss_pkg::COMP_OFFSET_RST;
         comp_slope_ff    <= bmss_pkg::COMP_SLOPE_RST;
         duty_floor_ff    <= bmss_pkg::DUTY_FLOOR_RST;
         step_interval_ff <= bmss_pkg::STEP_INTERVAL_RST;
         ramp_time_ff     <= bmss_pkg::RAMP_TIME_RST;
      end else if (csr_write) begin
         unique case (paddr[4:2])
            bmss_pkg::REG_COMP_OFFSET:   comp_offset_ff   <= pwdata[11:0];
            bmss_pkg::REG_COMP_SLOPE:    comp_slope_ff    <= pwdata[9:0];
            bmss_pkg::REG_DUTY_FLOOR:    duty_floor_ff    <= pwdata[11:0];
            bmss_pkg::REG_STEP_INTERVAL: step_interval_ff <= pwdata[7:0];
            bmss_pkg::REG_RAMP_TIME:     ramp_time_ff     <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         bmss_pkg::REG_COMP_OFFSET:   prdata = 32'(comp_offset_ff);
         bmss_pkg::REG_COMP_SLOPE:    prdata = 32'(comp_slope_ff);
         bmss_pkg::REG_DUTY_FLOOR:    prdata = 32'(duty_floor_ff);
         bmss_pkg::REG_STEP_INTERVAL: prdata = 32'(step_interval_ff);
         bmss_pkg::REG_RAMP_TIME:     prdata = 32'(ramp_time_ff);
         default:                     prdata = 32'd0;
      endcase
   end

   assign comp_cfg.comp_offset = comp_offset_ff;
   assign comp_cfg.comp_slope  = comp_slope_ff;
   assign comp_cfg.duty_floor  = duty_floor_ff;

   // Everything moves together whenever the result register is free or drains
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   bmss_comp u_comp (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_valid),
      .in_run_cmd (req_run_cmd),
      .in_battery (req_battery_sample),
      .cfg        (comp_cfg),
      .out_item   (item)
   );

   // Tick state update
   always_comb begin
      phase_cmd  = phase_ff;
      phase_in   = phase_ff;
      duty_in    = duty_ff;
      target_in  = target_ff;
      inc_in     = inc_ff;
      start_base = start_ticks_ff;
      step_base  = step_ticks_ff;
      duty_sum   = {1'b0, duty_ff} + 13'(inc_ff);

      priority if (item.run_cmd == bmss_pkg::CMD_START && phase_ff == PH_STOP) begin
         phase_cmd = PH_KICK;
      end else if (item.run_cmd == bmss_pkg::CMD_STOP) begin
         phase_cmd = PH_STOP;
      end else begin
         phase_cmd = phase_ff;
      end
      phase_in = phase_cmd;

      unique case (phase_cmd)
         PH_STOP: begin
            duty_in    = 12'd0;
            start_base = 16'd0;
            step_base  = 8'd0;
         end
         PH_KICK: begin
            if (start_ticks_ff <= 16'd1) begin
               duty_in = bmss_pkg::KICK_DUTY;
            end else begin
               duty_in   = bmss_pkg::RAMP_START_DUTY;
               target_in = item.comp_duty;
               inc_in    = item.ramp_step;
               phase_in  = PH_RAMP;
            end
         end
         PH_RAMP: begin
            if (start_ticks_ff <= ramp_time_ff) begin
               if (step_ticks_ff >= step_interval_ff) begin
                  step_base = 8'd0;
                  if (duty_ff <= target_ff) begin
                     duty_in = duty_sum[12] ? bmss_pkg::DUTY_MAX : duty_sum[11:0];
                  end else begin
                     duty_in = target_ff;
                  end
               end
            end else begin
               // ramp over: pin the counter and follow the compensated duty
               start_base = ramp_time_ff;
               duty_in    = item.comp_duty;
            end
         end
         default: ;
      endcase

      start_ticks_in = start_base + 16'd1;
      step_ticks_in  = step_base + 8'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_STOP;
         duty_ff        <= 12'd0;
         target_ff      <= 12'd0;
         inc_ff         <= 6'd0;
         start_ticks_ff <= 16'd0;
         step_ticks_ff  <= 8'd0;
         rsp_valid_ff   <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= item.valid;
         if (item.valid) begin
            phase_ff       <= phase_in;
            duty_ff        <= duty_in;
            target_ff      <= target_in;
            inc_ff         <= inc_in;
            start_ticks_ff <= start_ticks_in;
            step_ticks_ff  <= step_ticks_in;
            rsp_duty_ff    <= duty_in;
            rsp_phase_ff   <= phase_in;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_brush_duty = rsp_duty_ff;
   assign rsp_ramp_phase = rsp_phase_ff;

   // A waiting result must block new transfers
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request taken while result stalled");

   // Stopped motor always drives zero duty
   a_stop_zero_duty: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_STOP) |-> (duty_ff == 12'd0))
      else $error("nonzero duty while stopped");

   // Kick lasts at most two ticks
   a_kick_short: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_KICK) |-> (start_ticks_ff <= 16'd2))
      else $error("kick phase overran");

   // A new result only appears from a valid pipeline item
   a_rsp_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(item.valid))
      else $error("result without item");

endmodule

`default_nettype wire
